// ----- design/sfr_pkg.sv -----
package sfr_pkg;

	// Window and replacement limits; lengths written above these are clamped.
	localparam int MAX_PATTERN     = 8;
	localparam int MAX_REPLACEMENT = 8;

	// Longest run of output bytes one request can cause.
	localparam int RUN_MAX = (MAX_PATTERN > MAX_REPLACEMENT) ? MAX_PATTERN : MAX_REPLACEMENT;
	localparam int LEN_W   = $clog2(RUN_MAX + 1);
	localparam int IDX_W   = (RUN_MAX > 1) ? $clog2(RUN_MAX) : 1;
	localparam int CNT_W   = 4;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] NEWLINE_BYTE = 8'd10;

	typedef enum logic [0:0] {
		OP_DATA  = 1'b0,
		OP_FLUSH = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_PATTERN_BYTES      = 2'd0,
		REG_PATTERN_LENGTH     = 2'd1,
		REG_REPLACEMENT_BYTES  = 2'd2,
		REG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [63:0] pattern_bytes;
		logic [3:0]  pattern_length;
		logic [63:0] replacement_bytes;
		logic [3:0]  replacement_length;
	} cfg_t;

	// One run of output bytes, first byte in entry zero.
	typedef struct packed {
		logic [RUN_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]        len;
	} run_t;

	function automatic logic [3:0] clamp_len(input logic [3:0] v, input logic [3:0] maxv);
		logic [3:0] r;
		if (v == 4'd0) begin
			r = 4'd1;
		end else if (v > maxv) begin
			r = maxv;
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

// ----- design/sfr_front.sv -----
module sfr_front import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       s_tvalid,
	input  logic       s_tready,
	input  logic [7:0] s_tdata,
	input  logic [0:0] s_tuser,
	output logic       push,
	output run_t       run
);

	localparam logic [3:0] PAT_MAX  = 4'(MAX_PATTERN);
	localparam logic [3:0] REPL_MAX = 4'(MAX_REPLACEMENT);

	logic [7:0]       win_q [MAX_PATTERN];
	logic [CNT_W-1:0] cnt_q;
	logic [3:0]       act_len_q;

	logic             fire;
	logic [3:0]       act_len;
	logic [7:0]       win_next [MAX_PATTERN];
	logic [MAX_PATTERN-1:0] eq_vec;
	logic [CNT_W-1:0] new_cnt;
	logic [CNT_W-1:0] cnt_d;
	logic             is_newline;
	logic             is_flush;
	logic             full;
	logic             match;
	logic             store_en;
	logic             shift_en;

	assign fire       = s_tvalid && s_tready;
	assign is_flush   = (op_t'(s_tuser) == OP_FLUSH);
	assign is_newline = (s_tdata == NEWLINE_BYTE);
	assign new_cnt    = cnt_q + CNT_W'(1);

	always_comb begin
		act_len = (cnt_q == '0) ? clamp_len(cfg.pattern_length, PAT_MAX) : act_len_q;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			win_next[i] = (CNT_W'(i) == cnt_q) ? s_tdata : win_q[i];
			eq_vec[i]   = (win_next[i] == cfg.pattern_bytes[i*8 +: 8]) ||
			              (4'(i) >= act_len);
		end
		match = &eq_vec;
		full  = (new_cnt >= act_len);
	end

	always_comb begin
		for (int i = 0; i < RUN_MAX; i++) begin
			run.bytes[i] = (i < MAX_PATTERN) ? win_next[i] : 8'd0;
		end
		run.len  = '0;
		cnt_d    = cnt_q;
		store_en = 1'b0;
		shift_en = 1'b0;
		if (is_flush) begin
			run.len = LEN_W'(cnt_q);
			cnt_d   = '0;
		end else if (is_newline) begin
			// The newline already sits just past the held bytes.
			run.len = LEN_W'(new_cnt);
			cnt_d   = '0;
		end else begin
			store_en = 1'b1;
			cnt_d    = new_cnt;
			if (full) begin
				if (match) begin
					for (int i = 0; i < RUN_MAX; i++) begin
						run.bytes[i] = (i < MAX_REPLACEMENT) ?
						               cfg.replacement_bytes[i*8 +: 8] : 8'd0;
					end
					run.len = LEN_W'(clamp_len(cfg.replacement_length, REPL_MAX));
					cnt_d   = '0;
				end else begin
					run.len  = LEN_W'(1);
					cnt_d    = cnt_q;
					shift_en = 1'b1;
				end
			end
		end
	end

	assign push = fire && (run.len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			act_len_q <= 4'd1;
		end else if (fire) begin
			cnt_q     <= cnt_d;
			act_len_q <= act_len;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && store_en) begin
			if (shift_en) begin
				for (int i = 0; i < MAX_PATTERN - 1; i++) begin
					win_q[i] <= win_next[i+1];
				end
			end else begin
				win_q[cnt_q[IDX_W-1:0]] <= s_tdata;
			end
		end
	end

`ifndef SYNTHESIS
	// The window never holds a full pattern between requests.
	a_cnt_below_len: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < act_len_q)
		else $error("window count reached active pattern length");

	a_len_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(act_len_q != 4'd0) && (act_len_q <= PAT_MAX))
		else $error("active pattern length out of range");
`endif

endmodule

// ----- design/sfr_queue.sv -----
module sfr_queue import sfr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  run_t push_run,
	output logic not_full,
	input  logic pop,
	output logic not_empty,
	output run_t pop_run
);

	run_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign not_full  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_run   = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_run;
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> not_full)
		else $error("request queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("request queue read while empty");
`endif

endmodule

// ----- design/sfr_back.sv -----
module sfr_back import sfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_not_empty,
	input  run_t       q_run,
	output logic       q_pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic       m_tlast
);

	run_t             cur_q;
	logic [IDX_W-1:0] idx_q;
	logic             busy_q;
	logic             last;
	logic             done;

	assign last     = (LEN_W'(idx_q) + LEN_W'(1) == cur_q.len);
	assign done     = busy_q && m_tready && last;
	assign q_pop    = q_not_empty && (!busy_q || done);
	assign m_tvalid = busy_q;
	assign m_tdata  = cur_q.bytes[idx_q];
	assign m_tlast  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (q_pop) begin
			busy_q <= 1'b1;
			idx_q  <= '0;
		end else if (done) begin
			busy_q <= 1'b0;
		end else if (busy_q && m_tready) begin
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_run;
		end
	end

`ifndef SYNTHESIS
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cur_q.len != '0) && (LEN_W'(idx_q) < cur_q.len))
		else $error("output index past end of run");
`endif

endmodule

// ----- design/stream_find_replace.sv -----
// Streaming find-and-replace on a byte stream. Each data byte on the slave
// side enters a lookahead window as long as the configured pattern; when the
// window fills and equals the pattern, the replacement bytes go out and the
// window empties, otherwise the oldest byte goes out. A newline byte, or an
// end-of-stream request (tuser high), flushes the window unmatched, so matches
// never span lines, and a newline passes through unchanged. Every output byte
// is one master-side request, and tlast marks the final byte caused by one
// input request; an end-of-stream request with an empty window causes none.
// The front end takes one input request per clock while its two-entry run
// queue has room; the back end sends one byte per clock while m_tready is
// high, so the block sustains one byte per cycle in and out. A replacement
// or flush run holds the output, and input stalls only once two whole runs
// are queued behind it. A new pattern length applies when the window is empty.
// The user must write configuration only while idle; nothing here enforces it.
module stream_find_replace import sfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_tuser,   // [0] operation (1 = end of stream)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tlast
);

	cfg_t cfg_q;
	logic push;
	run_t push_run;
	logic q_not_full;
	logic q_not_empty;
	logic q_pop;
	run_t q_run;

	// Configuration registers; only the low nibble of the length writes is kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= 4'd1;
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= 4'd1;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_PATTERN_BYTES:      cfg_q.pattern_bytes      <= cfg_data;
				REG_PATTERN_LENGTH:     cfg_q.pattern_length     <= cfg_data[3:0];
				REG_REPLACEMENT_BYTES:  cfg_q.replacement_bytes  <= cfg_data;
				REG_REPLACEMENT_LENGTH: cfg_q.replacement_length <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Input is taken whenever the run queue can hold one more run.
	assign s_tready = q_not_full;

	sfr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.push     (push),
		.run      (push_run)
	);

	sfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_run  (push_run),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.pop_run   (q_run)
	);

	sfr_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_run       (q_run),
		.q_pop       (q_pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

// ----- tb/sv/stream_find_replace_tb.sv -----
// Self-checking bench for the streaming find-and-replace block. Input requests are
// driven on the slave side and output bytes are collected on the master side.
// A predictor inside the bench holds its own lookahead window and register copies.
// It works out the output run that every accepted input request should cause.
// The monitor compares each output byte and its tlast flag with the oldest entry
// in the queue of bytes still owed by the block.
module stream_find_replace_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sfr_pkg::*;

	// One output request as the master side should present it.
	typedef struct packed {
		logic [7:0] b;
		logic       last;
	} out_req_t;

	// A row of the directed table: a register write or an input request. When
	// typed is set, the expected run is given right in the row (no bytes or one
	// byte) and is used in place of the predictor's run.
	typedef struct {
		bit          is_cfg;
		cfg_reg_t    idx;
		logic [63:0] val;
		op_t         op;
		logic [7:0]  b;
		bit          typed;
		int          tcnt;
		logic [7:0]  tbyte;
	} dir_row_t;

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        cfg_wr_en = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = '0;   // [7:0] data_byte
	logic [0:0]  s_tuser   = '0;   // [0] operation (1 = end of stream)
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [7:0]  m_tdata;          // [7:0] out_byte
	logic        m_tlast;

	stream_find_replace dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	// Predictor state: register copies as the block holds them after reset,
	// the lookahead window and the pattern length that is currently in force.
	logic [63:0] pat_reg  = '0;
	logic [3:0]  plen_reg = 4'd1;
	logic [63:0] rep_reg  = '0;
	logic [3:0]  rlen_reg = 4'd1;
	logic [7:0]  window [MAX_PATTERN];
	int unsigned win_fill   = 0;
	int unsigned live_plen  = 1;

	out_req_t step_run[$];        // run caused by the request just accepted
	out_req_t expected_bytes[$];  // everything still owed by the block
	dir_row_t directed_rows[$];

	// Idle rates in percent per cycle, and the receiver's long hold-off.
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left   = 0;

	int err_cnt       = 0;
	int items_sent    = 0;
	int bytes_checked = 0;
	int replaced_runs = 0;
	int newline_items = 0;
	int flush_items   = 0;
	int settings_used = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// A run that never ends is a failure too.
	initial begin
		#3_000_000;
		$display("%0t: timeout, %0d output bytes still outstanding", $time,
			expected_bytes.size());
		$display("stream_find_replace_tb failed");
		$finish;
	end

	// Lengths of zero count as one, and lengths above the limit as the limit.
	function automatic int unsigned eff_len(input logic [3:0] v, input int unsigned maxv);
		if (v == 4'd0)
			return 1;
		if (v > maxv)
			return maxv;
		return 32'(v);
	endfunction

	function automatic out_req_t mk_out(input logic [7:0] b, input logic last);
		out_req_t r;
		r.b = b;
		r.last = last;
		return r;
	endfunction

	task automatic flush_window();
		for (int i = 0; i < win_fill; i++)
			step_run.push_back(mk_out(window[i], 1'b0));
		win_fill = 0;
	endtask

	// Works out the output run of one input request and advances the window.
	task automatic predict_run(input op_t op, input logic [7:0] d);
		bit         hit;
		out_req_t   tail;
		step_run.delete();
		// The pattern length is only picked up while the window is empty, so a
		// length written in the middle of a partial match waits for the next one.
		if (win_fill == 0)
			live_plen = eff_len(plen_reg, MAX_PATTERN);
		if (op == OP_FLUSH) begin
			flush_items++;
			flush_window();
		end else if (d == NEWLINE_BYTE) begin
			// Matches never cross a line: the window drains unmatched, then the
			// newline itself follows.
			newline_items++;
			flush_window();
			step_run.push_back(mk_out(d, 1'b0));
		end else begin
			if (win_fill < MAX_PATTERN) begin
				window[win_fill] = d;
				win_fill++;
			end
			if (win_fill >= live_plen) begin
				hit = 1'b1;
				for (int i = 0; i < live_plen; i++)
					if (window[i] != pat_reg[8*i +: 8])
						hit = 1'b0;
				if (hit) begin
					replaced_runs++;
					for (int i = 0; i < eff_len(rlen_reg, MAX_REPLACEMENT); i++)
						step_run.push_back(mk_out(rep_reg[8*i +: 8], 1'b0));
					win_fill = 0;
				end else begin
					// No match: the oldest byte leaves and the rest move down.
					step_run.push_back(mk_out(window[0], 1'b0));
					for (int i = 1; i < win_fill; i++)
						window[i-1] = window[i];
					win_fill--;
				end
			end
		end
		if (step_run.size() > 0) begin
			tail = step_run.pop_back();
			tail.last = 1'b1;
			step_run.push_back(tail);
		end
	endtask

	// Offers one input request, waits for the handshake and records what the
	// block now owes. Valid stays high from one request to the next unless the
	// sender decides to idle, so back-to-back requests keep a single assignment
	// per clock edge.
	task automatic send_req(input op_t op, input logic [7:0] d, input bit typed,
			input int tcnt, input logic [7:0] tbyte);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tuser  <= op;
		do
			@(posedge clk);
		while (!s_tready);
		items_sent++;
		predict_run(op, d);
		if (typed) begin
			if (tcnt == 1)
				expected_bytes.push_back(mk_out(tbyte, 1'b1));
		end else begin
			foreach (step_run[i])
				expected_bytes.push_back(step_run[i]);
		end
	endtask

	// Brings the block to rest: stops offering input, waits for every owed byte
	// and reports any that never arrive. A flush of an empty window owes nothing
	// and puts no run into the two-entry run queue.
	task automatic settle_block();
		int guard;
		guard = 0;
		s_tvalid <= 1'b0;
		while (expected_bytes.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_bytes.size() != 0) begin
			$display("%0t: %0d expected output bytes never arrived", $time,
				expected_bytes.size());
			err_cnt++;
			expected_bytes.delete();
		end
		repeat (16) @(posedge clk);
	endtask

	// The write takes effect at the edge where cfg_wr_en is seen high.
	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_PATTERN_BYTES: begin
				pat_reg = v;
			end
			REG_PATTERN_LENGTH: begin
				plen_reg = v[3:0];
			end
			REG_REPLACEMENT_BYTES: begin
				rep_reg = v;
			end
			REG_REPLACEMENT_LENGTH: begin
				rlen_reg = v[3:0];
			end
		endcase
	endtask

	task automatic load_setting(input logic [63:0] pat, input logic [63:0] plen,
			input logic [63:0] rep, input logic [63:0] rlen);
		settle_block();
		write_reg(REG_PATTERN_BYTES, pat);
		write_reg(REG_PATTERN_LENGTH, plen);
		write_reg(REG_REPLACEMENT_BYTES, rep);
		write_reg(REG_REPLACEMENT_LENGTH, rlen);
		settings_used++;
	endtask

	function automatic void add_req(input op_t op, input logic [7:0] b, input bit typed,
			input int tcnt, input logic [7:0] tbyte);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.idx    = REG_PATTERN_BYTES;
		r.val    = '0;
		r.op     = op;
		r.b      = b;
		r.typed  = typed;
		r.tcnt   = tcnt;
		r.tbyte  = tbyte;
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(input cfg_reg_t idx, input logic [63:0] val);
		dir_row_t r;
		r.is_cfg = 1'b1;
		r.idx    = idx;
		r.val    = val;
		r.op     = OP_DATA;
		r.b      = '0;
		r.typed  = 1'b0;
		r.tcnt   = 0;
		r.tbyte  = '0;
		directed_rows.push_back(r);
	endfunction

	// A word of lowercase letters from a three-letter alphabet, so that random
	// traffic keeps running into partial and overlapping matches.
	function automatic logic [63:0] letter_word();
		logic [63:0] w;
		for (int i = 0; i < 8; i++)
			w[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 2));
		return w;
	endfunction

	// Random traffic for the current setting. Most of it is the pattern itself
	// or a prefix of it broken off by a stray byte; the rest is noise, newlines
	// and end-of-stream requests, which cut a partial match short.
	task automatic run_random(input int n_items);
		int          sent;
		int          kind;
		int          plen;
		int          cut;
		logic [7:0]  b;
		plen = eff_len(plen_reg, MAX_PATTERN);
		sent = 0;
		while (sent < n_items) begin
			kind = $urandom_range(0, 99);
			if (kind < 42) begin
				for (int k = 0; k < plen; k++)
					send_req(OP_DATA, pat_reg[8*k +: 8], 1'b0, 0, 8'h00);
				sent += plen;
			end else if (kind < 62) begin
				cut = $urandom_range(0, plen - 1);
				for (int k = 0; k < cut; k++)
					send_req(OP_DATA, pat_reg[8*k +: 8], 1'b0, 0, 8'h00);
				b = 8'($urandom_range(0, 255));
				send_req(OP_DATA, b, 1'b0, 0, 8'h00);
				sent += cut + 1;
			end else if (kind < 74) begin
				cut = $urandom_range(0, plen - 1);
				send_req(OP_DATA, pat_reg[8*cut +: 8], 1'b0, 0, 8'h00);
				sent++;
			end else if (kind < 86) begin
				b = 8'($urandom_range(0, 255));
				send_req(OP_DATA, b, 1'b0, 0, 8'h00);
				sent++;
			end else if (kind < 93) begin
				send_req(OP_DATA, NEWLINE_BYTE, 1'b0, 0, 8'h00);
				sent++;
			end else begin
				// The data byte of an end-of-stream request is don't-care, so it
				// carries random bits.
				b = 8'($urandom_range(0, 255));
				send_req(OP_FLUSH, b, 1'b0, 0, 8'h00);
				sent++;
			end
		end
	endtask

	// Receiver: random ready, or a long hold-off counted down here while the
	// sender keeps pushing, which fills the run queue and stalls the input.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	// Output checker: every accepted byte is matched against the oldest owed one.
	always @(posedge clk) begin : check_output
		out_req_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected output byte %02h last %0b", $time, m_tdata,
					m_tlast);
				err_cnt++;
			end else begin
				want = expected_bytes.pop_front();
				bytes_checked++;
				if (m_tdata !== want.b) begin
					$display("%0t: out_byte expected %02h got %02h", $time, want.b,
						m_tdata);
					err_cnt++;
				end
				if (m_tlast !== want.last) begin
					$display("%0t: last_of_run expected %0b got %0b", $time, want.last,
						m_tlast);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		// Registers after reset: pattern byte 0 of length one, and replacement
		// byte 0 of length one, so a zero byte maps onto itself.
		add_req(OP_FLUSH, 8'h5A, 1'b1, 0, 8'h00);          // empty window: no output
		add_req(OP_DATA, NEWLINE_BYTE, 1'b1, 1, NEWLINE_BYTE); // newline alone
		add_req(OP_DATA, 8'h00, 1'b1, 1, 8'h00);           // match, replaced by 00
		add_req(OP_DATA, 8'hFF, 1'b1, 1, 8'hFF);
		add_req(OP_DATA, 8'h41, 1'b1, 1, 8'h41);
		// Pattern "abc" with the longest replacement "ABCDEFGH".
		add_cfg(REG_PATTERN_BYTES, 64'h0000_0000_0063_6261);
		add_cfg(REG_PATTERN_LENGTH, 64'd3);
		add_cfg(REG_REPLACEMENT_BYTES, 64'h4847_4645_4443_4241);
		add_cfg(REG_REPLACEMENT_LENGTH, 64'd8);
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h62, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h63, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h62, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h78, 1'b0, 0, 8'h00);
		add_req(OP_FLUSH, 8'h00, 1'b0, 0, 8'h00);           // drains the partial window
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, NEWLINE_BYTE, 1'b0, 0, 8'h00);     // match cut off by a newline
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h62, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h63, 1'b0, 0, 8'h00);
		// Shortening the pattern with two bytes in the window: the old length of
		// three still decides this match, the new one applies afterwards.
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h62, 1'b0, 0, 8'h00);
		add_cfg(REG_PATTERN_LENGTH, 64'd2);
		add_req(OP_DATA, 8'h63, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h62, 1'b0, 0, 8'h00);
		// New pattern bytes apply at once, even to a half-filled window.
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_cfg(REG_PATTERN_BYTES, 64'h0000_0000_0000_7A61);
		add_req(OP_DATA, 8'h7A, 1'b0, 0, 8'h00);
		// A replacement length of zero behaves as one.
		add_cfg(REG_REPLACEMENT_LENGTH, 64'd0);
		add_req(OP_DATA, 8'h61, 1'b0, 0, 8'h00);
		add_req(OP_DATA, 8'h7A, 1'b0, 0, 8'h00);

		tx_idle_pct = 8;
		rx_idle_pct = 73;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		settings_used = 1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				settle_block();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_req(directed_rows[i].op, directed_rows[i].b, directed_rows[i].typed,
					directed_rows[i].tcnt, directed_rows[i].tbyte);
			end
		end

		// Sender mostly busy, receiver mostly idle.
		load_setting(letter_word(), 64'd3, {$urandom, $urandom}, 64'd8);
		run_random(65);
		// Longest pattern from fully random bytes, shortest replacement.
		load_setting({$urandom, $urandom}, 64'd8, {$urandom, $urandom}, 64'd1);
		run_random(65);

		// Sender mostly idle, receiver mostly ready.
		tx_idle_pct = 73;
		rx_idle_pct = 8;
		// Zero lengths in the low nibble with the upper bits set: both count as one.
		load_setting({$urandom, $urandom}, 64'hFFFF_FFFF_FFFF_FFF0, {$urandom, $urandom},
			64'hFFFF_FFFF_FFFF_FFF0);
		run_random(65);
		// All-ones pattern, lengths of fifteen clamped to eight.
		load_setting(64'hFFFF_FFFF_FFFF_FFFF, 64'd15, 64'hFFFF_FFFF_FFFF_FFFF, 64'd15);
		run_random(65);

		// No idling at all. The first of these settings starts with a long
		// receiver hold-off while the sender streams, so the run queue fills up.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		load_setting(letter_word(), 64'd2, letter_word(), 64'd5);
		hold_left = 300;
		run_random(65);
		load_setting(letter_word(), 64'd4, {$urandom, $urandom}, 64'd3);
		run_random(65);

		settle_block();

		$display("Sent %0d requests (%0d newlines, %0d end-of-stream) over %0d register settings.",
			items_sent, newline_items, flush_items, settings_used);
		$display("Checked %0d output bytes, %0d of the requests completed a pattern match.",
			bytes_checked, replaced_runs);
		if (err_cnt == 0) begin
			$display("stream_find_replace_tb passed");
		end else begin
			$display("stream_find_replace_tb failed");
		end
		$finish;
	end

endmodule
